/* hdl/srme_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and entry type of the sparse row merge engine.
package srme_pkg;

    localparam int ROW_LENGTH_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int RES_W          = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W   = 2;
    localparam int COL_W   = 5;
    localparam int VAL_W   = 32;
    localparam int MODE_W  = 2;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // input commands
    localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

    // run operations
    localparam logic [MODE_W-1:0] OP_ADD = 2'd0;
    localparam logic [MODE_W-1:0] OP_SUB = 2'd1;
    localparam logic [MODE_W-1:0] OP_DOT = 2'd2;

    // register byte address
    localparam logic [PADDR_W-1:0] ADDR_OP_MODE = 2'd0;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] val;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* hdl/sparse_row_merge_engine.sv */
`timescale 1ns / 1ps
// Top level of the sparse row merge engine: row loading, merge sequencer, output register.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+--------------------------------------------
//   request   | i_in_valid / o_in_ready   | i_cmd, i_column, i_value
//   result    | o_out_valid / i_out_ready | o_out_column, o_out_value, o_nonzero,
//             |                           | o_saturated, o_last
//   config    | psel penable pwrite pready| paddr, pwdata, prdata (op_mode at address 0)
//
// Each merge step reads both row heads in S_READ (one read port per row RAM, registered
// read) and compares them in S_STEP; a dot-product match then passes S_ACC (multiply, then
// the shared adder accumulates), each nonzero result S_PUSH. A run ends when a compare finds
// nothing left to merge or the result limit is hit; S_FIN then posts the final result. The
// merge steps never exceed ROW_LENGTH. No clearing pass after reset; reset is synchronous.
// A run waits while a result meets a full output register; no request is taken until it ends.
module sparse_row_merge_engine #(
    parameter int ROW_LENGTH = srme_pkg::ROW_LENGTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [srme_pkg::CMD_W-1:0]    i_cmd,
    input  logic [srme_pkg::COL_W-1:0]    i_column,
    input  logic signed [srme_pkg::VAL_W-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [srme_pkg::COL_W-1:0]    o_out_column,
    output logic signed [srme_pkg::VAL_W-1:0] o_out_value,
    output logic                          o_nonzero,
    output logic                          o_saturated,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srme_pkg::PADDR_W-1:0]  paddr,
    input  logic [srme_pkg::PDATA_W-1:0]  pwdata,
    output logic [srme_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import srme_pkg::*;

    localparam int CNT_W = $clog2(ROW_LENGTH + 1);
    localparam int AW    = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;
    localparam int ACC_W = 48 + CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // control state
    logic [2:0]        r_state, n_state;
    logic [MODE_W-1:0] r_op_mode;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [COL_W-1:0]  r_last_a, n_last_a, r_last_b, n_last_b;
    logic              r_pend_v, n_pend_v;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic [CNT_W-1:0]        r_i, n_i, r_j, n_j;
    logic [RES_W-1:0]        r_found, n_found;
    logic [ACC_W-1:0]        r_acc, n_acc;
    logic signed [63:0]      r_prod, n_prod;
    logic [COL_W-1:0]        r_new_col, n_new_col, r_pend_col, n_pend_col;
    logic [VAL_W-1:0]        r_new_val, n_new_val, r_pend_val, n_pend_val;
    logic                    r_new_sat, n_new_sat, r_pend_sat, n_pend_sat;
    logic [COL_W-1:0]        r_out_col, n_out_col;
    logic [VAL_W-1:0]        r_out_val, n_out_val;
    logic                    r_out_nz, n_out_nz, r_out_sat, n_out_sat;
    logic                    r_out_last, n_out_last;

    logic   w_in_acc, w_out_free, w_cfg_wr;
    logic   w_col_ok, w_ok_a, w_ok_b, w_we_a, w_we_b;
    t_entry w_wdata, w_ra, w_rb;
    logic   w_a_ok, w_b_ok, w_take_a, w_take_b, w_res_done;
    logic signed [63:0] w_prod;
    logic [ACC_W-1:0]   w_add_x, w_add_y, w_sum, w_sat_in;
    logic               w_add_sub;
    logic [ACC_W-32:0]  w_hi;
    logic               w_sat;
    logic [VAL_W-1:0]   w_sat_val;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == ADDR_OP_MODE) ? {{(PDATA_W-MODE_W){1'b0}}, r_op_mode}
                                              : '0;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // load checks
    assign w_col_ok = (i_column != '0) && (32'(i_column) <= 32'(ROW_LENGTH));
    assign w_ok_a   = w_col_ok && (i_column > r_last_a) && (r_cnt_a < CNT_W'(ROW_LENGTH));
    assign w_ok_b   = w_col_ok && (i_column > r_last_b) && (r_cnt_b < CNT_W'(ROW_LENGTH));
    assign w_we_a   = w_in_acc && (i_cmd == CMD_LOAD_A) && w_ok_a;
    assign w_we_b   = w_in_acc && (i_cmd == CMD_LOAD_B) && w_ok_b;
    assign w_wdata  = '{col: i_column, val: i_value};

    srme_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROW_LENGTH)
    ) u_row_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_i[AW-1:0]),
        .o_rdata (w_ra)
    );

    srme_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROW_LENGTH)
    ) u_row_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (w_rb)
    );

    // merge decision on the two row heads
    assign w_a_ok   = (r_i < r_cnt_a);
    assign w_b_ok   = (r_j < r_cnt_b);
    assign w_take_a = w_a_ok && (!w_b_ok || (w_ra.col <= w_rb.col));
    assign w_take_b = w_b_ok && (!w_a_ok || (w_rb.col <= w_ra.col));

    assign w_prod = w_ra.val * w_rb.val;

    // shared adder: merge sum/difference in S_STEP, accumulate in S_ACC
    always_comb begin
        if (r_state == S_ACC) begin
            w_add_x   = r_acc;
            w_add_y   = {{(ACC_W-48){r_prod[63]}}, r_prod[63:16]};
            w_add_sub = 1'b0;
        end else begin
            w_add_x   = w_take_a ? {{(ACC_W-VAL_W){w_ra.val[VAL_W-1]}}, w_ra.val} : '0;
            w_add_y   = w_take_b ? {{(ACC_W-VAL_W){w_rb.val[VAL_W-1]}}, w_rb.val} : '0;
            w_add_sub = (r_op_mode == OP_SUB);
        end
    end

    assign w_sum = w_add_x + (w_add_sub ? ~w_add_y : w_add_y) + ACC_W'(w_add_sub);

    // saturate to 32 bits
    assign w_sat_in  = (r_state == S_FIN) ? r_acc : w_sum;
    assign w_hi      = w_sat_in[ACC_W-1:31];
    assign w_sat     = !((&w_hi) || !(|w_hi));
    assign w_sat_val = !w_sat ? w_sat_in[VAL_W-1:0]
                     : (w_sat_in[ACC_W-1] ? VAL_MIN : VAL_MAX);

    assign w_res_done = (r_found == RES_W'(MAX_RESULTS));

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_last_a    = r_last_a;
        n_last_b    = r_last_b;
        n_pend_v    = r_pend_v;
        n_out_valid = r_out_valid;
        n_i         = r_i;
        n_j         = r_j;
        n_found     = r_found;
        n_acc       = r_acc;
        n_prod      = r_prod;
        n_new_col   = r_new_col;
        n_new_val   = r_new_val;
        n_new_sat   = r_new_sat;
        n_pend_col  = r_pend_col;
        n_pend_val  = r_pend_val;
        n_pend_sat  = r_pend_sat;
        n_out_col   = r_out_col;
        n_out_val   = r_out_val;
        n_out_nz    = r_out_nz;
        n_out_sat   = r_out_sat;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_cmd)
                        CMD_LOAD_A: begin
                            if (w_ok_a) begin
                                n_cnt_a  = r_cnt_a + 1'b1;
                                n_last_a = i_column;
                            end
                        end
                        CMD_LOAD_B: begin
                            if (w_ok_b) begin
                                n_cnt_b  = r_cnt_b + 1'b1;
                                n_last_b = i_column;
                            end
                        end
                        CMD_RUN: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_acc   = '0;
                            n_found = '0;
                            n_state = (r_op_mode == OP_ADD || r_op_mode == OP_SUB ||
                                       r_op_mode == OP_DOT) ? S_READ : S_FIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_op_mode == OP_DOT) begin
                    if (w_a_ok && w_b_ok) begin
                        n_state = S_READ;
                        if (w_ra.col < w_rb.col) begin
                            n_i = r_i + 1'b1;
                        end else if (w_ra.col > w_rb.col) begin
                            n_j = r_j + 1'b1;
                        end else begin
                            n_i     = r_i + 1'b1;
                            n_j     = r_j + 1'b1;
                            n_prod  = w_prod;
                            n_state = S_ACC;
                        end
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (!w_a_ok && !w_b_ok) begin
                    n_state = S_FIN;
                end else begin
                    if (w_take_a) begin
                        n_i = r_i + 1'b1;
                    end
                    if (w_take_b) begin
                        n_j = r_j + 1'b1;
                    end
                    if (w_sum != '0) begin
                        n_new_col = w_take_a ? w_ra.col : w_rb.col;
                        n_new_val = w_sat_val;
                        n_new_sat = w_sat;
                        n_found   = r_found + 1'b1;
                        n_state   = S_PUSH;
                    end else begin
                        // drop zero result
                        n_state = S_READ;
                    end
                end
            end
            S_ACC: begin
                n_acc   = w_sum;
                n_state = S_READ;
            end
            S_PUSH: begin
                // hold one result back so the final one can carry last
                if (!r_pend_v || w_out_free) begin
                    if (r_pend_v) begin
                        n_out_valid = 1'b1;
                        n_out_col   = r_pend_col;
                        n_out_val   = r_pend_val;
                        n_out_nz    = 1'b1;
                        n_out_sat   = r_pend_sat;
                        n_out_last  = 1'b0;
                    end
                    n_pend_v   = 1'b1;
                    n_pend_col = r_new_col;
                    n_pend_val = r_new_val;
                    n_pend_sat = r_new_sat;
                    n_state    = w_res_done ? S_FIN : S_READ;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_op_mode == OP_DOT) begin
                        n_out_col = '0;
                        n_out_val = w_sat_val;
                        n_out_nz  = (r_acc != '0);
                        n_out_sat = w_sat;
                    end else if (r_pend_v) begin
                        n_out_col = r_pend_col;
                        n_out_val = r_pend_val;
                        n_out_nz  = 1'b1;
                        n_out_sat = r_pend_sat;
                    end else begin
                        n_out_col = '0;
                        n_out_val = '0;
                        n_out_nz  = 1'b0;
                        n_out_sat = 1'b0;
                    end
                    n_pend_v = 1'b0;
                    n_cnt_a  = '0;
                    n_cnt_b  = '0;
                    n_last_a = '0;
                    n_last_b = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op_mode   <= OP_ADD;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_last_a    <= '0;
            r_last_b    <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_last_a    <= n_last_a;
            r_last_b    <= n_last_b;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && (paddr == ADDR_OP_MODE)) begin
                r_op_mode <= pwdata[MODE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_found    <= n_found;
        r_acc      <= n_acc;
        r_prod     <= n_prod;
        r_new_col  <= n_new_col;
        r_new_val  <= n_new_val;
        r_new_sat  <= n_new_sat;
        r_pend_col <= n_pend_col;
        r_pend_val <= n_pend_val;
        r_pend_sat <= n_pend_sat;
        r_out_col  <= n_out_col;
        r_out_val  <= n_out_val;
        r_out_nz   <= n_out_nz;
        r_out_sat  <= n_out_sat;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_column = r_out_col;
    assign o_out_value  = r_out_val;
    assign o_nonzero    = r_out_nz;
    assign o_saturated  = r_out_sat;
    assign o_last       = r_out_last;

    a_pend_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("held result outside a run");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(ROW_LENGTH)) && (r_cnt_b <= CNT_W'(ROW_LENGTH)))
        else $error("row count beyond row length");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_out_free) |=>
        (r_cnt_a == '0 && r_cnt_b == '0 && r_state == S_IDLE && o_out_valid && o_last))
        else $error("run end did not clear rows or post last result");

    a_found_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_found <= RES_W'(MAX_RESULTS)))
        else $error("result count beyond limit");

    a_mid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_nonzero)
        else $error("empty result not at end of run");

endmodule

/* hdl/srme_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module srme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* test/sparse_row_merge_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the sparse row merge engine: directed and random merge requests.
module sparse_row_merge_engine_tb;

    import srme_pkg::*;

    localparam int ROW_LEN       = ROW_LENGTH_DEF;
    localparam int COL_MAX       = (1 << COL_W) - 1;
    localparam int SETTLE_CYCLES = 4 * ROW_LEN + 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 370;
    localparam int MAX_REPORTS   = 50;

    localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0] OP_UNUSED  = 2'd3;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] val;
        logic             nonzero;
        logic             saturated;
        logic             last;
    } t_merge_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_cmd = CMD_LOAD_A;
    logic [COL_W-1:0]          i_column = '0;
    logic signed [VAL_W-1:0]   i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [COL_W-1:0]          o_out_column;
    logic signed [VAL_W-1:0]   o_out_value;
    logic                      o_nonzero;
    logic                      o_saturated;
    logic                      o_last;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    // shadow copy of the engine: mode register and both rows
    logic [MODE_W-1:0]         shadow_mode = OP_ADD;
    logic [COL_W-1:0]          shadow_col[2][ROW_LEN];
    logic signed [VAL_W-1:0]   shadow_val[2][ROW_LEN];
    int                        shadow_count[2];
    logic [COL_W-1:0]          shadow_last[2];

    t_merge_result             expected_merge_results[$];

    int  n_loads = 0;
    int  n_runs = 0;
    int  n_ignored = 0;
    int  n_results = 0;
    int  n_mode_writes = 0;
    int  n_errors = 0;
    int  stall_left = 0;
    bit  rx_calm = 1'b0;
    bit  tx_calm = 1'b0;

    sparse_row_merge_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_column     (i_column),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_column (o_out_column),
        .o_out_value  (o_out_value),
        .o_nonzero    (o_nonzero),
        .o_saturated  (o_saturated),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3, 4, 5: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_merge_result make_result(input logic [COL_W-1:0] col, input longint v,
                                                  input logic nz);
        t_merge_result res;
        res.col       = col;
        res.nonzero   = nz;
        res.saturated = 1'b0;
        res.last      = 1'b0;
        if (v > Q_MAX) begin
            v = Q_MAX;
            res.saturated = 1'b1;
        end else if (v < Q_MIN) begin
            v = Q_MIN;
            res.saturated = 1'b1;
        end
        res.val = v[VAL_W-1:0];
        return res;
    endfunction

    // Apply one accepted request to the shadow rows; a run queues its merged results.
    function automatic void predict_merge_request(input logic [CMD_W-1:0] cmd,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [VAL_W-1:0] val);
        t_merge_result run_out[MAX_RESULTS];
        int n, i, j, r;
        longint acc, sum, sgn, va, vb;
        logic [COL_W-1:0] c;
        if (cmd == CMD_LOAD_A || cmd == CMD_LOAD_B) begin
            r = (cmd == CMD_LOAD_B) ? 1 : 0;
            if (col >= 1 && col <= ROW_LEN && col > shadow_last[r] &&
                shadow_count[r] < ROW_LEN) begin
                shadow_col[r][shadow_count[r]] = col;
                shadow_val[r][shadow_count[r]] = val;
                shadow_count[r]++;
                shadow_last[r] = col;
                n_loads++;
            end else begin
                n_ignored++;
            end
            return;
        end
        if (cmd != CMD_RUN) begin
            n_ignored++;
            return;
        end
        n_runs++;
        n = 0;
        i = 0;
        j = 0;
        if (shadow_mode == OP_DOT) begin
            acc = 0;
            while (i < shadow_count[0] && j < shadow_count[1]) begin
                if (shadow_col[0][i] < shadow_col[1][j]) begin
                    i++;
                end else if (shadow_col[0][i] > shadow_col[1][j]) begin
                    j++;
                end else begin
                    va = shadow_val[0][i];
                    vb = shadow_val[1][j];
                    // truncate each product toward minus infinity, accumulate exactly
                    acc += (va * vb) >>> 16;
                    i++;
                    j++;
                end
            end
            run_out[0] = make_result('0, acc, acc != 0);
            n = 1;
        end else if (shadow_mode == OP_ADD || shadow_mode == OP_SUB) begin
            sgn = (shadow_mode == OP_SUB) ? -1 : 1;
            while ((i < shadow_count[0] || j < shadow_count[1]) && n < MAX_RESULTS) begin
                if (j >= shadow_count[1] ||
                    (i < shadow_count[0] && shadow_col[0][i] < shadow_col[1][j])) begin
                    c   = shadow_col[0][i];
                    sum = shadow_val[0][i];
                    i++;
                end else if (i >= shadow_count[0] || shadow_col[1][j] < shadow_col[0][i]) begin
                    vb  = shadow_val[1][j];
                    c   = shadow_col[1][j];
                    sum = sgn * vb;
                    j++;
                end else begin
                    va  = shadow_val[0][i];
                    vb  = shadow_val[1][j];
                    c   = shadow_col[0][i];
                    sum = va + sgn * vb;
                    i++;
                    j++;
                end
                if (sum != 0) begin
                    run_out[n] = make_result(c, sum, 1'b1);
                    n++;
                end
            end
        end
        if (n == 0) begin
            run_out[0] = make_result('0, 0, 1'b0);
            n = 1;
        end
        run_out[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_merge_results.push_back(run_out[k]);
        shadow_count[0] = 0;
        shadow_count[1] = 0;
        shadow_last[0]  = '0;
        shadow_last[1]  = '0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            if (n_errors < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    task automatic check_merge_result();
        t_merge_result want;
        n_results++;
        if (expected_merge_results.size() == 0) begin
            if (n_errors < MAX_REPORTS)
                $display("%0t: unexpected result, expected none, actual col %0d value %h last %b",
                         $time, o_out_column, o_out_value, o_last);
            n_errors++;
        end else begin
            want = expected_merge_results.pop_front();
            check_field("out_column", want.col, o_out_column);
            check_field("out_value", want.val, o_out_value);
            check_field("nonzero", want.nonzero, o_nonzero);
            check_field("saturated", want.saturated, o_saturated);
            check_field("last", want.last, o_last);
        end
    endtask

    // Result side: check every accepted result, stall at random with calm stretches.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_merge_result();
        if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_left = rx_calm ? 0 : pick_gap();
        end
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [COL_W-1:0] col,
                                input logic [VAL_W-1:0] val);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_column   <= col;
        i_value    <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predict_merge_request(cmd, col, val);
    endtask

    task automatic write_op_mode(input logic [MODE_W-1:0] mode);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_OP_MODE;
        pwdata  <= {{(PDATA_W-MODE_W){1'b0}}, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_mode = mode;
        n_mode_writes++;
    endtask

    // Drop valid, drain all results, then let a possible trailing load settle.
    task automatic wait_merge_idle();
        i_in_valid <= 1'b0;
        while (expected_merge_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_noise();
        logic [CMD_W-1:0] row_cmd;
        int row;
        row = $urandom_range(0, 1);
        row_cmd = row ? CMD_LOAD_B : CMD_LOAD_A;
        case ($urandom_range(0, 3))
            0: send_request(row_cmd, '0, $urandom);
            1: send_request(row_cmd, COL_W'($urandom_range(ROW_LEN + 1, COL_MAX)), $urandom);
            2: send_request(CMD_UNUSED, COL_W'($urandom_range(0, COL_MAX)), $urandom);
            default: send_request(row_cmd, shadow_last[row], $urandom);
        endcase
    endtask

    // Two well-formed rows with random content, loads interleaved with noise, then mostly a run.
    task automatic send_merge_sequence();
        logic [COL_W-1:0] a_col[ROW_LEN];
        logic [COL_W-1:0] b_col[ROW_LEN];
        logic [VAL_W-1:0] a_val[ROW_LEN];
        logic [VAL_W-1:0] b_val[ROW_LEN];
        logic [VAL_W-1:0] a_at;
        bit in_a, in_b;
        int dens, na, nb, ia, ib, r;
        r = $urandom_range(0, 99);
        if (r < 70) dens = $urandom_range(5, 30);
        else if (r < 95) dens = $urandom_range(30, 80);
        else dens = 100;
        na = 0;
        nb = 0;
        for (int c = 1; c <= ROW_LEN; c++) begin
            in_a = $urandom_range(0, 99) < dens;
            in_b = in_a ? ($urandom_range(0, 99) < 60) : ($urandom_range(0, 99) < dens);
            if (in_a) begin
                a_at = rand_q16();
                a_col[na] = COL_W'(c);
                a_val[na] = a_at;
                na++;
            end
            if (in_b) begin
                b_col[nb] = COL_W'(c);
                // bias shared columns toward cancellation in add and subtract
                case ($urandom_range(0, 3))
                    0: b_val[nb] = in_a ? a_at : rand_q16();
                    1: b_val[nb] = in_a ? -a_at : rand_q16();
                    default: b_val[nb] = rand_q16();
                endcase
                nb++;
            end
        end
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                send_request(CMD_LOAD_A, a_col[ia], a_val[ia]);
                ia++;
            end else begin
                send_request(CMD_LOAD_B, b_col[ib], b_val[ib]);
                ib++;
            end
        end
        // now and then leave the rows loaded so the next sequence hits stale state
        if ($urandom_range(0, 9) != 0)
            send_request(CMD_RUN, COL_W'($urandom_range(0, COL_MAX)), $urandom);
    endtask

    task automatic send_broken_sequence();
        repeat ($urandom_range(1, 8))
            send_request(CMD_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, COL_MAX)),
                         $urandom);
        send_request(CMD_RUN, COL_W'($urandom_range(0, COL_MAX)), $urandom);
    endtask

    task automatic test_add_saturation_and_bad_loads();
        wait_merge_idle();
        write_op_mode(OP_ADD);
        send_request(CMD_LOAD_A, 5'd1, VAL_MAX);
        send_request(CMD_LOAD_B, 5'd1, 32'sd1);
        send_request(CMD_LOAD_B, 5'd2, -32'sd5);
        send_request(CMD_LOAD_A, 5'd3, 32'sd5);
        send_request(CMD_LOAD_A, 5'd16, VAL_MIN);
        send_request(CMD_LOAD_B, 5'd16, -32'sd1);
        send_request(CMD_LOAD_A, 5'd0, 32'sd7);
        send_request(CMD_LOAD_B, 5'd17, 32'sd7);
        send_request(CMD_LOAD_A, 5'd31, 32'sd7);
        send_request(CMD_LOAD_A, 5'd16, 32'sd9);
        send_request(CMD_UNUSED, 5'd5, 32'hFFFF_FFFF);
        send_request(CMD_RUN, 5'd0, 32'h0);
    endtask

    task automatic test_sub_cancel_and_empty();
        wait_merge_idle();
        write_op_mode(OP_SUB);
        send_request(CMD_LOAD_A, 5'd4, 32'sh10000);
        send_request(CMD_LOAD_B, 5'd4, 32'sh10000);
        send_request(CMD_LOAD_B, 5'd7, VAL_MIN);
        send_request(CMD_LOAD_A, 5'd9, 32'sd0);
        send_request(CMD_RUN, 5'd0, 32'h0);
        send_request(CMD_RUN, 5'd0, 32'h0);
    endtask

    task automatic test_dot_product();
        wait_merge_idle();
        write_op_mode(OP_DOT);
        send_request(CMD_LOAD_A, 5'd5, -32'sd3);
        send_request(CMD_LOAD_B, 5'd5, 32'sh8001);
        send_request(CMD_LOAD_A, 5'd7, 32'sd1);
        send_request(CMD_LOAD_B, 5'd6, 32'sd2);
        send_request(CMD_RUN, 5'd0, 32'h0);
        send_request(CMD_LOAD_A, 5'd2, VAL_MAX);
        send_request(CMD_LOAD_B, 5'd2, VAL_MAX);
        send_request(CMD_RUN, 5'd0, 32'h0);
        send_request(CMD_RUN, 5'd0, 32'h0);
    endtask

    task automatic test_unused_mode();
        wait_merge_idle();
        write_op_mode(OP_UNUSED);
        send_request(CMD_LOAD_A, 5'd1, 32'sd1);
        send_request(CMD_LOAD_B, 5'd1, 32'sd1);
        send_request(CMD_RUN, 5'd0, 32'h0);
    endtask

    task automatic test_random_merges();
        logic [MODE_W-1:0] mode;
        int target, phase;
        target = n_loads + n_runs + RANDOM_ITEMS;
        phase = 0;
        while (n_loads + n_runs < target) begin
            wait_merge_idle();
            case (phase)
                0: mode = OP_ADD;
                1: mode = OP_SUB;
                2: mode = OP_DOT;
                3: mode = OP_UNUSED;
                default: begin
                    case ($urandom_range(0, 11))
                        0: mode = OP_UNUSED;
                        1, 2, 3, 4: mode = OP_DOT;
                        5, 6, 7: mode = OP_SUB;
                        default: mode = OP_ADD;
                    endcase
                end
            endcase
            write_op_mode(mode);
            repeat ($urandom_range(3, 8)) begin
                if (n_loads + n_runs < target) begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 9) == 0) send_broken_sequence();
                    else send_merge_sequence();
                end
            end
            phase++;
        end
        tx_calm = 1'b0;
    endtask

    initial begin
        int guard;
        shadow_count[0] = 0;
        shadow_count[1] = 0;
        shadow_last[0]  = '0;
        shadow_last[1]  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_add_saturation_and_bad_loads();
        test_sub_cancel_and_empty();
        test_dot_product();
        test_unused_mode();
        test_random_merges();

        i_in_valid <= 1'b0;
        guard = 0;
        while (expected_merge_results.size() > 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (expected_merge_results.size() > 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_merge_results.size());
            n_errors += expected_merge_results.size();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Accepted %0d loads and %0d runs, %0d dropped or ignored requests.",
                 n_loads, n_runs, n_ignored);
        $display("Checked %0d results over %0d op_mode writes, %0d errors.",
                 n_results, n_mode_writes, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
